### rtl/pkcsp_pkg.sv
`default_nettype none

package pkcsp_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned LEN_FIELD_BYTES = 4;

  // byte roles, also the parse phase codes
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_PLEN   = 3'd1;
  localparam logic [2:0] PH_PATH   = 3'd2;
  localparam logic [2:0] PH_NUL    = 3'd3;
  localparam logic [2:0] PH_DLEN   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_IGNORE = 3'd6;

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MAGIC      = 3'd1;
  localparam logic [2:0] ST_VERSION    = 3'd2;
  localparam logic [2:0] ST_SIZE       = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_PATH_UNTERM = 3'd5;
  localparam logic [2:0] ST_PATH_EMPTY = 3'd6;
  localparam logic [2:0] ST_OVERFLOW   = 3'd7;

  // header fault codes
  localparam logic [1:0] HF_NONE    = 2'd0;
  localparam logic [1:0] HF_MAGIC   = 2'd1;
  localparam logic [1:0] HF_VERSION = 2'd2;

  localparam logic [7:0] MAGIC_P = 8'h50;
  localparam logic [7:0] MAGIC_K = 8'h4B;
  localparam logic [7:0] MAGIC_G = 8'h47;

  typedef struct packed {
    logic [2:0] final_status;
    logic       stream_complete;
    logic       entry_complete;
    logic [2:0] byte_role;
    logic [7:0] byte_value;
  } pkcsp_result_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] stream_byte;
  } pkcsp_item_t;

  function automatic logic [7:0] pkcsp_magic(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = MAGIC_P;
      2'd1:    m = MAGIC_K;
      default: m = MAGIC_G;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/pkcsp_beat_reg.sv
`default_nettype none

module pkcsp_beat_reg #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic [W-1:0] data;
  logic         valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

`default_nettype wire

### rtl/pkcsp_core.sv
`default_nettype none

module pkcsp_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire pkcsp_pkg::pkcsp_item_t item,
  input  wire logic [7:0]             expected_version,
  output pkcsp_pkg::pkcsp_result_t    result
);

  import pkcsp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] CAP = {LENGTH_BITS{1'b1}};
  localparam logic [FIELD_W-1:0] CAP32 = FIELD_W'(CAP);
  localparam logic [LENGTH_BITS-1:0] IDX_VERSION = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] IDX_HDR_END = LENGTH_BITS'(HEADER_BYTES - 1);
  localparam logic [FIELD_W-1:0] FIELD_LEN = FIELD_W'(LEN_FIELD_BYTES);

  logic [2:0]             phase, phase_next;
  logic [FIELD_W-1:0]     field_rem, field_rem_next;
  logic [FIELD_W-1:0]     len_shift, len_shift_next;
  logic [LENGTH_BITS-1:0] bytes_seen, bytes_seen_next;
  logic                   count_sat, count_sat_next;
  logic [FIELD_W-1:0]     decl_size, decl_size_next;
  logic [1:0]             hdr_fault, hdr_fault_next;
  logic [2:0]             ent_fault, ent_fault_next;

  logic [7:0]         b;
  logic [FIELD_W-1:0] shifted;
  logic [FIELD_W-1:0] rem_dec;
  logic               at_cap;
  logic [2:0]         role;
  logic               done;
  logic [2:0]         status;

  assign b       = item.stream_byte;
  assign shifted = {len_shift[FIELD_W-9:0], b};
  assign rem_dec = field_rem - FIELD_W'(1);
  assign at_cap  = (bytes_seen == CAP);

  always_comb begin
    phase_next      = phase;
    field_rem_next  = field_rem;
    len_shift_next  = len_shift;
    bytes_seen_next = at_cap ? bytes_seen : bytes_seen + LENGTH_BITS'(1);
    count_sat_next  = count_sat || at_cap;
    decl_size_next  = decl_size;
    hdr_fault_next  = hdr_fault;
    ent_fault_next  = ent_fault;
    role            = phase;
    done            = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        if (bytes_seen < IDX_VERSION) begin
          if (b != pkcsp_magic(bytes_seen[1:0]) && hdr_fault == HF_NONE) begin
            hdr_fault_next = HF_MAGIC;
          end
        end else if (bytes_seen == IDX_VERSION) begin
          if (b != expected_version && hdr_fault == HF_NONE) begin
            hdr_fault_next = HF_VERSION;
          end
        end else begin
          decl_size_next = {decl_size[FIELD_W-9:0], b};
        end
        if (bytes_seen == IDX_HDR_END) begin
          phase_next     = (hdr_fault_next != HF_NONE) ? PH_IGNORE : PH_PLEN;
          field_rem_next = FIELD_LEN;
          len_shift_next = '0;
        end
      end
      PH_PLEN: begin
        len_shift_next = shifted;
        field_rem_next = rem_dec;
        if (rem_dec == '0) begin
          if (shifted == '0) begin
            ent_fault_next = ST_PATH_EMPTY;
            phase_next     = PH_IGNORE;
          end else if (shifted > CAP32 - FIELD_W'(1)) begin
            ent_fault_next = ST_OVERFLOW;
            phase_next     = PH_IGNORE;
          end else begin
            phase_next     = PH_PATH;
            field_rem_next = shifted;
          end
        end
      end
      PH_PATH: begin
        field_rem_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_NUL;
        end
      end
      PH_NUL: begin
        if (b != 8'd0) begin
          ent_fault_next = ST_PATH_UNTERM;
          phase_next     = PH_IGNORE;
        end else begin
          phase_next     = PH_DLEN;
          field_rem_next = FIELD_LEN;
          len_shift_next = '0;
        end
      end
      PH_DLEN: begin
        len_shift_next = shifted;
        field_rem_next = rem_dec;
        if (rem_dec == '0) begin
          if (shifted == '0) begin
            done           = 1'b1;
            phase_next     = PH_PLEN;
            field_rem_next = FIELD_LEN;
            len_shift_next = '0;
          end else begin
            phase_next     = PH_DATA;
            field_rem_next = shifted;
          end
        end
      end
      PH_DATA: begin
        field_rem_next = rem_dec;
        if (rem_dec == '0) begin
          done           = 1'b1;
          phase_next     = PH_PLEN;
          field_rem_next = FIELD_LEN;
          len_shift_next = '0;
        end
      end
      default: begin
        phase_next = PH_IGNORE;
        role       = PH_IGNORE;
      end
    endcase

    // final status in priority order, from the state after this byte
    status = ST_OK;
    if (item.last_byte) begin
      if (phase_next == PH_HEADER) begin
        status = ST_TRUNCATED;
      end else if (hdr_fault_next != HF_NONE) begin
        status = {1'b0, hdr_fault_next};
      end else if (count_sat_next || decl_size_next != FIELD_W'(bytes_seen_next)) begin
        status = ST_SIZE;
      end else if (ent_fault_next != ST_OK) begin
        status = ent_fault_next;
      end else if (!(phase_next == PH_PLEN && field_rem_next == FIELD_LEN)) begin
        status = ST_TRUNCATED;
      end
    end
  end

  assign result.byte_value      = b;
  assign result.byte_role       = role;
  assign result.entry_complete  = done;
  assign result.stream_complete = item.last_byte;
  assign result.final_status    = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      field_rem  <= '0;
      len_shift  <= '0;
      bytes_seen <= '0;
      count_sat  <= 1'b0;
      decl_size  <= '0;
      hdr_fault  <= HF_NONE;
      ent_fault  <= ST_OK;
    end else if (step) begin
      if (item.last_byte) begin
        // a new stream starts with the next beat
        phase      <= PH_HEADER;
        field_rem  <= '0;
        len_shift  <= '0;
        bytes_seen <= '0;
        count_sat  <= 1'b0;
        decl_size  <= '0;
        hdr_fault  <= HF_NONE;
        ent_fault  <= ST_OK;
      end else begin
        phase      <= phase_next;
        field_rem  <= field_rem_next;
        len_shift  <= len_shift_next;
        bytes_seen <= bytes_seen_next;
        count_sat  <= count_sat_next;
        decl_size  <= decl_size_next;
        hdr_fault  <= hdr_fault_next;
        ent_fault  <= ent_fault_next;
      end
    end
  end

  a_entry_fault_ignores: assert property (@(posedge clk) disable iff (rst)
    ent_fault != ST_OK |-> phase == PH_IGNORE)
    else $error("entry fault recorded but parser still active");

  a_header_fault_ignores: assert property (@(posedge clk) disable iff (rst)
    (hdr_fault != HF_NONE && phase != PH_HEADER) |-> phase == PH_IGNORE)
    else $error("header fault but entries being parsed");

  a_sat_at_cap: assert property (@(posedge clk) disable iff (rst)
    count_sat |-> bytes_seen == CAP)
    else $error("byte count saturated below cap");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (step && item.last_byte) |=> (phase == PH_HEADER && bytes_seen == '0))
    else $error("parser not cleared after last beat");

endmodule

`default_nettype wire

### rtl/package_container_stream_parser.sv
// channel | dir | handshake        | payload
// s_*     | in  | s_tvalid/s_tready | s_tdata stream byte, s_tlast last byte
// m_*     | out | m_tvalid/m_tready | m_tdata value and status, m_tuser role and
//         |     |                   |   entry end, m_tlast stream complete
// cfg_*   | in  | cfg_we            | cfg_wdata expected version
//
// an accepted input beat reaches its output beat through an input register,
// then the parser state update and the result register
// one beat per cycle sustained while m_tready is high; the parser state steps once per beat
// rst is synchronous; it clears the parser and sets the expected version to 1
// a stalled m side holds its beat while the input register takes one more
`default_nettype none

module package_container_stream_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] byte_value, [10:8] final_status, rest zero
  output logic [3:0]       m_tuser,   // [2:0] byte_role, [3] entry_complete
  output logic             m_tlast,   // stream_complete
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  import pkcsp_pkg::*;

  localparam int unsigned ITEM_W = $bits(pkcsp_item_t);
  localparam int unsigned RES_W  = $bits(pkcsp_result_t);

  logic [7:0]    expected_version;
  pkcsp_item_t   s_item;
  logic [ITEM_W-1:0] item_bits;
  pkcsp_item_t   item;
  logic          item_valid;
  logic          res_ready;
  logic          step;
  pkcsp_result_t res;
  logic [RES_W-1:0] out_bits;
  pkcsp_result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
    end else if (cfg_we) begin
      expected_version <= cfg_wdata;
    end
  end

  assign s_item.stream_byte = s_tdata;
  assign s_item.last_byte   = s_tlast;

  pkcsp_beat_reg #(.W(ITEM_W)) u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_item),
    .out_valid (item_valid),
    .out_ready (res_ready),
    .out_data  (item_bits)
  );

  assign item = pkcsp_item_t'(item_bits);
  assign step = item_valid && res_ready;

  pkcsp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .item             (item),
    .expected_version (expected_version),
    .result           (res)
  );

  pkcsp_beat_reg #(.W(RES_W)) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_bits)
  );

  assign out_res = pkcsp_result_t'(out_bits);
  assign m_tdata = {5'd0, out_res.final_status, out_res.byte_value};
  assign m_tuser = {out_res.entry_complete, out_res.byte_role};
  assign m_tlast = out_res.stream_complete;

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pkcsp_pkg::*;

  localparam int unsigned LEN_BITS = 32;
  localparam logic [31:0] LEN_CAP = 32'hFFFF_FFFF >> (32 - LEN_BITS);
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_BYTES = 260;
  localparam int DIR_N = 27;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [2:0] role;
    logic       done;
    logic [2:0] status;
  } dir_row_t;

  // short header, a clean one-entry stream, a header with the wrong version
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{MAGIC_P, 1'b1, 1'b1, PH_HEADER, 1'b0, ST_TRUNCATED},
    '{MAGIC_P, 1'b0, 1'b1, PH_HEADER, 1'b0, ST_OK},
    '{MAGIC_K, 1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{MAGIC_G, 1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h01,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'd18,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h01,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'hFF,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b1, 1'b1, PH_DLEN,   1'b1, ST_OK},
    '{MAGIC_P, 1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{MAGIC_K, 1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{MAGIC_G, 1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'hFF,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'hFF,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'h00,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'hFF,   1'b0, 1'b0, PH_HEADER, 1'b0, ST_OK},
    '{8'hFF,   1'b1, 1'b1, PH_HEADER, 1'b0, ST_VERSION}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;

  package_container_stream_parser #(
    .LENGTH_BITS(LEN_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // parser state as the predictor tracks it
  logic [2:0]  phase;
  logic [31:0] fld_left;
  logic [31:0] len_acc;
  logic [31:0] byte_count;
  logic        count_sat;
  logic [31:0] size_field;
  logic [1:0]  hdr_fault;
  logic [2:0]  ent_fault;
  logic [7:0]  want_version = 8'd1;

  pkcsp_result_t parsed_q[$];
  pkcsp_result_t got_res;
  pkcsp_result_t exp_res;
  logic [7:0]    pkt[$];

  int err_cnt = 0;
  int bytes_sent = 0;
  int streams_sent = 0;
  int entries_done = 0;
  int settings_run = 0;
  int status_cnt[8];
  int burst_left = 0;
  int idle_cyc = 0;
  int rx_mode = 1;
  int rx_cyc = 0;

  function automatic void clear_parse();
    phase = PH_HEADER;
    fld_left = '0;
    len_acc = '0;
    byte_count = '0;
    count_sat = 1'b0;
    size_field = '0;
    hdr_fault = HF_NONE;
    ent_fault = ST_OK;
  endfunction

  function automatic pkcsp_result_t parse_byte(input logic [7:0] b, input logic fin);
    pkcsp_result_t r;
    logic [31:0]   idx;
    logic [2:0]    role;
    logic          done;
    logic [2:0]    status;
    logic [7:0]    magic;
    idx = byte_count;
    role = phase;
    done = 1'b0;
    status = ST_OK;
    if (byte_count >= LEN_CAP) count_sat = 1'b1;
    else byte_count = byte_count + 1;
    case (phase)
      PH_HEADER: begin
        if (idx < 3) begin
          magic = (idx == 0) ? MAGIC_P : (idx == 1) ? MAGIC_K : MAGIC_G;
          if (b != magic && hdr_fault == HF_NONE) hdr_fault = HF_MAGIC;
        end else if (idx == 3) begin
          if (b != want_version && hdr_fault == HF_NONE) hdr_fault = HF_VERSION;
        end else begin
          size_field = {size_field[23:0], b};
        end
        if (idx == HEADER_BYTES - 1) begin
          phase = (hdr_fault != HF_NONE) ? PH_IGNORE : PH_PLEN;
          fld_left = LEN_FIELD_BYTES;
          len_acc = '0;
        end
      end
      PH_PLEN: begin
        len_acc = {len_acc[23:0], b};
        fld_left = fld_left - 1;
        if (fld_left == 0) begin
          if (len_acc == 0) begin
            ent_fault = ST_PATH_EMPTY;
            phase = PH_IGNORE;
          end else if (len_acc > LEN_CAP - 1) begin
            ent_fault = ST_OVERFLOW;
            phase = PH_IGNORE;
          end else begin
            phase = PH_PATH;
            fld_left = len_acc;
          end
        end
      end
      PH_PATH: begin
        fld_left = fld_left - 1;
        if (fld_left == 0) phase = PH_NUL;
      end
      PH_NUL: begin
        if (b != 8'h00) begin
          ent_fault = ST_PATH_UNTERM;
          phase = PH_IGNORE;
        end else begin
          phase = PH_DLEN;
          fld_left = LEN_FIELD_BYTES;
          len_acc = '0;
        end
      end
      PH_DLEN: begin
        len_acc = {len_acc[23:0], b};
        fld_left = fld_left - 1;
        if (fld_left == 0) begin
          if (len_acc == 0) begin
            done = 1'b1;
            phase = PH_PLEN;
            fld_left = LEN_FIELD_BYTES;
            len_acc = '0;
          end else begin
            phase = PH_DATA;
            fld_left = len_acc;
          end
        end
      end
      PH_DATA: begin
        fld_left = fld_left - 1;
        if (fld_left == 0) begin
          done = 1'b1;
          phase = PH_PLEN;
          fld_left = LEN_FIELD_BYTES;
          len_acc = '0;
        end
      end
      default: begin
        phase = PH_IGNORE;
        role = PH_IGNORE;
      end
    endcase
    if (fin) begin
      if (phase == PH_HEADER) status = ST_TRUNCATED;
      else if (hdr_fault != HF_NONE) status = (hdr_fault == HF_MAGIC) ? ST_MAGIC : ST_VERSION;
      else if (count_sat || size_field != byte_count) status = ST_SIZE;
      else if (ent_fault != ST_OK) status = ent_fault;
      else if (!(phase == PH_PLEN && fld_left == LEN_FIELD_BYTES)) status = ST_TRUNCATED;
      clear_parse();
    end
    r.byte_value = b;
    r.byte_role = role;
    r.entry_complete = done;
    r.stream_complete = fin;
    r.final_status = status;
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input pkcsp_result_t typed_res);
    pkcsp_result_t pred;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    pred = parse_byte(b, fin);
    parsed_q.push_back(typed ? typed_res : pred);
    bytes_sent++;
    if (fin) streams_sent++;
  endtask

  // hold the sender until every expected beat is out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_version = v;
    settings_run++;
  endtask

  task automatic add_entry(input logic [31:0] plen, input logic [31:0] dlen,
                           input logic [7:0] nul);
    for (int i = 3; i >= 0; i--) pkt.push_back(plen[8*i +: 8]);
    repeat ((plen > 64) ? 8 : plen) pkt.push_back(8'($urandom));
    pkt.push_back(nul);
    for (int i = 3; i >= 0; i--) pkt.push_back(dlen[8*i +: 8]);
    repeat ((dlen > 64) ? 12 : dlen) pkt.push_back(8'($urandom));
  endtask

  // mostly well-formed streams, each with at most one kind of damage
  task automatic build_stream();
    int          fault;
    int          cut;
    logic [31:0] sz;
    pkt.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
      return;
    end
    pkt = '{MAGIC_P, MAGIC_K, MAGIC_G, want_version, 8'h00, 8'h00, 8'h00, 8'h00};
    repeat ($urandom_range(0, 3))
      add_entry(($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6),
                ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10), 8'h00);
    fault = $urandom_range(0, 99);
    if (fault >= 60 && fault < 65) add_entry(0, $urandom_range(0, 4), 8'h00);
    else if (fault >= 65 && fault < 70) add_entry(32'hFFFF_FFFF, $urandom_range(0, 4), 8'h00);
    else if (fault >= 70 && fault < 75)
      add_entry($urandom_range(1, 4), $urandom_range(0, 4), 8'($urandom_range(1, 255)));
    else if (fault >= 75 && fault < 80)
      add_entry($urandom_range(1, 4), {1'b1, 31'($urandom)}, 8'h00);
    else if (fault >= 80 && fault < 85 && pkt.size() > 9) begin
      cut = $urandom_range(9, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    sz = pkt.size();
    if (fault >= 85 && fault < 90) begin
      case ($urandom_range(0, 2))
        0: sz = sz + $urandom_range(1, 3);
        1: sz = sz - 1;
        default: sz = $urandom;
      endcase
    end
    if (fault >= 90 && fault < 93) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) pkt[4 + i] = sz[8*(3 - i) +: 8];
    if (fault >= 93 && fault < 96) begin
      cut = $urandom_range(0, 2);
      pkt[cut] = pkt[cut] ^ 8'($urandom_range(1, 255));
    end
    if (fault >= 96 && fault < 98) pkt[3] = pkt[3] ^ 8'($urandom_range(1, 255));
    if (fault >= 98) begin
      cut = $urandom_range(1, 7);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  // receiver: always ready, random stalls, short periodic stalls, long stalls
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 2) != 0);
      2: m_tready <= (rx_cyc % 16 < 11);
      default: m_tready <= (rx_cyc % 64 >= 20);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.byte_value = m_tdata[7:0];
      got_res.final_status = m_tdata[10:8];
      got_res.byte_role = m_tuser[2:0];
      got_res.entry_complete = m_tuser[3];
      got_res.stream_complete = m_tlast;
      if (parsed_q.size() == 0) begin
        flag_error($sformatf("unexpected beat value %02h role %0d", got_res.byte_value,
                             got_res.byte_role));
      end else begin
        exp_res = parsed_q.pop_front();
        if (got_res != exp_res || m_tdata[15:11] != '0)
          flag_error($sformatf({"expected value %02h role %0d end %0b last %0b status %0d, ",
                                "got value %02h role %0d end %0b last %0b status %0d pad %0h"},
                               exp_res.byte_value, exp_res.byte_role, exp_res.entry_complete,
                               exp_res.stream_complete, exp_res.final_status,
                               got_res.byte_value, got_res.byte_role, got_res.entry_complete,
                               got_res.stream_complete, got_res.final_status, m_tdata[15:11]));
        if (exp_res.stream_complete) status_cnt[exp_res.final_status]++;
        if (exp_res.entry_complete) entries_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("%0t stuck: no beat for %0d cycles, %0d beats pending", $realtime, idle_cyc,
                 parsed_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    pkcsp_result_t typed_res;
    int            phase_start;
    clear_parse();
    for (int i = 0; i < 8; i++) status_cnt[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      typed_res.byte_value = DIR_TAB[i].b;
      typed_res.byte_role = DIR_TAB[i].role;
      typed_res.entry_complete = DIR_TAB[i].done;
      typed_res.stream_complete = DIR_TAB[i].fin;
      typed_res.final_status = DIR_TAB[i].status;
      send_byte(DIR_TAB[i].b, DIR_TAB[i].fin, DIR_TAB[i].typed, typed_res);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_version(8'h00);
        1: write_version(8'hFF);
        3: write_version(8'h01);
        default: write_version(8'($urandom));
      endcase
      rx_mode = p % 4;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_stream();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
        if ($urandom_range(0, 14) == 0) drain();
      end
    end

    s_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes in %0d streams under %0d version settings, %0d entries ended",
             bytes_sent, streams_sent, settings_run, entries_done);
    $display("streams by status: ok %0d magic %0d version %0d size %0d trunc %0d unterm %0d %s",
             status_cnt[ST_OK], status_cnt[ST_MAGIC], status_cnt[ST_VERSION],
             status_cnt[ST_SIZE], status_cnt[ST_TRUNCATED], status_cnt[ST_PATH_UNTERM],
             $sformatf("empty %0d overflow %0d, %0d mismatches", status_cnt[ST_PATH_EMPTY],
                       status_cnt[ST_OVERFLOW], err_cnt));
    if (err_cnt == 0 && parsed_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### package_container_stream_parser.f
rtl/pkcsp_pkg.sv
rtl/pkcsp_beat_reg.sv
rtl/pkcsp_core.sv
rtl/package_container_stream_parser.sv
test/tb.sv
